@@ hw/rtl/smc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants
// Opcodes, CSR indices, ALU request/response types and field widths of the stack machine core.
// ----------------------------------------------------------------------------
package smc_pkg;

   localparam int OpW        = 6;
   localparam int WordW      = 64;
   localparam int PtrW       = 16;
   localparam int PcW        = 12;
   localparam int DataWords  = 4096;
   localparam int CodeWords  = 4096;
   localparam logic [PtrW-1:0] DefStackTop = 16'h8000;

   typedef enum logic [OpW-1:0] {
      OP_LLA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_JSR = 6'd3,
      OP_BZ  = 6'd4, OP_BNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7,
      OP_LEV = 6'd8, OP_LI  = 6'd9, OP_LC  = 6'd10, OP_SI = 6'd11,
      OP_SC  = 6'd12, OP_PSH = 6'd13, OP_OR = 6'd14, OP_XOR = 6'd15,
      OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
      OP_GT  = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23,
      OP_SHR = 6'd24, OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27,
      OP_DIV = 6'd28, OP_MOD = 6'd29, OP_EXIT = 6'd38
   } opcode_type;

   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_STACK = 2'd1;

   typedef struct packed {
      logic             start;
      logic [OpW-1:0]   op;
      logic [WordW-1:0] lhs;
      logic [WordW-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [WordW-1:0] result;
   } alu_rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/smc_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smc_alu: shared multicycle ALU
// Logic, compare, shift and add/sub ops, shift-add multiply and restoring
// divide, one bit per cycle.
// ----------------------------------------------------------------------------
module smc_alu
   import smc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_type;

   state_type        state_ff, state_in;
   logic [WordW-1:0] acc_ff, acc_in;
   logic [WordW-1:0] a_ff, a_in;
   logic [WordW-1:0] b_ff, b_in;
   logic [WordW:0]   rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, is_mod_ff, is_mod_in;
   logic [WordW-1:0] res_ff, res_in;

   logic signed [WordW-1:0] sl, sr;
   logic [5:0]       sh;
   logic [WordW-1:0] quick, abs_l, abs_r;
   logic [WordW:0]   trial;

   assign sl = req.lhs;
   assign sr = req.rhs;
   assign sh = req.rhs[5:0];
   assign abs_l = sl[WordW-1] ? (~req.lhs + 1'b1) : req.lhs;
   assign abs_r = sr[WordW-1] ? (~req.rhs + 1'b1) : req.rhs;
   assign trial = {rem_ff[WordW-1:0], a_ff[WordW-1]} - {1'b0, b_ff};

   always_comb begin
      case (req.op)
         OP_OR:   quick = req.lhs | req.rhs;
         OP_XOR:  quick = req.lhs ^ req.rhs;
         OP_AND:  quick = req.lhs & req.rhs;
         OP_EQ:   quick = {{(WordW-1){1'b0}}, req.lhs == req.rhs};
         OP_NE:   quick = {{(WordW-1){1'b0}}, req.lhs != req.rhs};
         OP_LT:   quick = {{(WordW-1){1'b0}}, sl < sr};
         OP_GT:   quick = {{(WordW-1){1'b0}}, sl > sr};
         OP_LE:   quick = {{(WordW-1){1'b0}}, sl <= sr};
         OP_GE:   quick = {{(WordW-1){1'b0}}, sl >= sr};
         OP_SHL:  quick = req.lhs << sh;
         OP_SHR:  quick = WordW'(sl >>> sh);
         OP_ADD:  quick = req.lhs + req.rhs;
         OP_SUB:  quick = req.lhs - req.rhs;
         default: quick = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff; acc_in = acc_ff; a_in = a_ff; b_in = b_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; neg_q_in = neg_q_ff; neg_r_in = neg_r_ff;
      is_mod_in = is_mod_ff; res_in = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               cnt_in = '0;
               if (req.op == OP_MUL) begin
                  acc_in = '0; a_in = req.lhs; b_in = req.rhs; state_in = ST_MUL;
               end else if ((req.op == OP_DIV) || (req.op == OP_MOD)) begin
                  is_mod_in = (req.op == OP_MOD);
                  if (req.rhs == '0) begin
                     res_in = '0; state_in = ST_DONE;
                  end else if (req.rhs == '1) begin
                     res_in = (req.op == OP_DIV) ? (~req.lhs + 1'b1) : '0;
                     state_in = ST_DONE;
                  end else begin
                     a_in = abs_l; b_in = abs_r; rem_in = '0;
                     neg_q_in = sl[WordW-1] ^ sr[WordW-1];
                     neg_r_in = sl[WordW-1];
                     state_in = ST_DIV;
                  end
               end else begin
                  res_in = quick; state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               res_in = b_ff[0] ? acc_ff + a_ff : acc_ff;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            a_in = {a_ff[WordW-2:0], ~trial[WordW]};
            rem_in = trial[WordW] ? {rem_ff[WordW-1:0], a_ff[WordW-1]} : trial;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (is_mod_ff)
                  res_in = neg_r_ff ? (~rem_in[WordW-1:0] + 1'b1) : rem_in[WordW-1:0];
               else
                  res_in = neg_q_ff ? (~a_in + 1'b1) : a_in;
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in;
      is_mod_ff <= is_mod_in; res_ff <= res_in;
   end

   assign rsp.done   = (state_ff == ST_DONE);
   assign rsp.result = res_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == ST_IDLE) else $error("alu start while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("alu done held");
   a_mul_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && cnt_ff == 6'd63) |=> rsp.done) else $error("mul length");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/stack_machine_core_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_core_unit: accumulator stack machine core
// Executes one instruction per request word; returns pc, acc and status.
// ----------------------------------------------------------------------------
// An instruction passes from request to response word through the data
// memory (read, execute/write, respond); LEV and SC add a second memory
// access, the other ALU ops a hand-off to the shared ALU, and MUL, DIV and
// MOD a bit-serial run in the shared ALU (but for a zero or minus-one
// divisor). Once halted, each word is answered in the cycle after it is
// taken. One instruction is in flight at a time, req_tready is low
// meanwhile, and the core idles after each response word until the next
// request is taken. Data words must be written before they are read.
module stack_machine_core_unit
   import smc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [71:0]  req_tdata,   // opcode[5:0], operand[69:6], zero
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,   // next_pc[11:0], acc_value[75:12],
                                          // halted[76], fault[77], exit_value[141:78]
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam int AW = $clog2(DataWords);
   localparam int CW = $clog2(CodeWords);

   typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EXEC, ST_RD2, ST_ALU, ST_RSP}
      state_type;

   state_type         state_ff, state_in;
   logic [PcW-1:0]    start_ff, pc_ff, pc_in;
   logic [PtrW-1:0]   top_ff, sp_ff, sp_in, fp_ff, fp_in;
   logic [WordW-1:0]  acc_ff, acc_in, exit_ff, exit_in, opd_ff;
   logic [OpW-1:0]    op_ff;
   logic              stop_ff, stop_in, fault_ff, fault_in;

   logic [WordW-1:0]  mem [DataWords];
   logic [WordW-1:0]  rdata_ff;
   logic [AW-1:0]     raddr, waddr;
   logic              re, we;
   logic [WordW-1:0]  wdata;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   logic [PcW-1:0]    pc1, pc2, tgt;
   logic [WordW-1:0]  b_sx, a_sx;
   logic [5:0]        lane, alane;
   logic [PtrW-1:0]   opd8;

   function automatic logic [PcW-1:0] pc_mod(input logic [WordW-1:0] v);
      pc_mod = PcW'(v[CW-1:0]);
   endfunction

   assign pc1  = pc_mod(WordW'(pc_ff) + 64'd1);
   assign pc2  = pc_mod(WordW'(pc_ff) + 64'd2);
   assign tgt  = pc_mod(opd_ff);
   assign opd8 = {opd_ff[PtrW-4:0], 3'b000};
   assign lane  = {opd_ff[2:0], 3'b000};
   assign alane = {acc_ff[2:0], 3'b000};
   assign b_sx  = {{56{acc_ff[7]}}, acc_ff[7:0]};
   assign a_sx  = WordW'($signed(8'(rdata_ff >> alane)));

   assign alu_req.start = (state_ff == ST_EXEC) && (op_ff >= OP_OR) && (op_ff <= OP_MOD);
   assign alu_req.op    = op_ff;
   assign alu_req.lhs   = rdata_ff;
   assign alu_req.rhs   = acc_ff;

   smc_alu u_alu (.clock(clock), .reset(reset), .req(alu_req), .rsp(alu_rsp));

   // memory control
   always_comb begin
      re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = '0;
      case (state_ff)
         ST_RD: begin
            re = 1'b1;
            if ((op_ff == OP_LI) || (op_ff == OP_LC)) raddr = AW'(acc_ff >> 3);
            else if (op_ff == OP_LEV) raddr = AW'(fp_ff >> 3);
            else raddr = AW'(sp_ff >> 3);
         end
         ST_EXEC: begin
            case (op_ff)
               OP_JSR: begin we = 1'b1; waddr = AW'(16'(sp_ff - 16'd8) >> 3);
                  wdata = WordW'(pc2); end
               OP_ENT: begin we = 1'b1; waddr = AW'(16'(sp_ff - 16'd8) >> 3);
                  wdata = WordW'(fp_ff); end
               OP_PSH: begin we = 1'b1; waddr = AW'(16'(sp_ff - 16'd8) >> 3);
                  wdata = acc_ff; end
               OP_SI:  begin we = 1'b1; waddr = AW'(rdata_ff >> 3); wdata = acc_ff; end
               OP_SC:  begin re = 1'b1; raddr = AW'(rdata_ff >> 3); end
               OP_LEV: begin re = 1'b1; raddr = AW'(16'(fp_ff + 16'd8) >> 3); end
               default: ;
            endcase
         end
         ST_RD2: begin
            if (op_ff == OP_SC) begin
               we = 1'b1; waddr = AW'(opd_ff >> 3);
               wdata = (rdata_ff & ~(64'hFF << lane))
                     | ({56'd0, acc_ff[7:0]} << lane);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; sp_in = sp_ff; fp_in = fp_ff;
      acc_in = acc_ff; stop_in = stop_ff; fault_in = fault_ff; exit_in = exit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               fault_in = 1'b0; exit_in = '0;
               state_in = stop_ff ? ST_RSP : ST_RD;
            end
         end
         ST_RD: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_RSP;
            case (op_ff)
               OP_LLA: begin acc_in = WordW'(fp_ff) + {opd_ff[WordW-4:0], 3'b000};
                  pc_in = pc2; end
               OP_IMM: begin acc_in = opd_ff; pc_in = pc2; end
               OP_JMP: pc_in = tgt;
               OP_JSR: begin sp_in = sp_ff - 16'd8; pc_in = tgt; end
               OP_BZ:  pc_in = (acc_ff != '0) ? pc2 : tgt;
               OP_BNZ: pc_in = (acc_ff != '0) ? tgt : pc2;
               OP_ENT: begin fp_in = sp_ff - 16'd8; sp_in = sp_ff - 16'd8 - opd8;
                  pc_in = pc2; end
               OP_ADJ: begin sp_in = sp_ff + opd8; pc_in = pc2; end
               OP_LEV: begin fp_in = rdata_ff[PtrW-1:0]; sp_in = fp_ff + 16'd16;
                  state_in = ST_RD2; end
               OP_LI:  begin acc_in = rdata_ff; pc_in = pc1; end
               OP_LC:  begin acc_in = a_sx; pc_in = pc1; end
               OP_SI:  begin sp_in = sp_ff + 16'd8; pc_in = pc1; end
               OP_SC:  begin sp_in = sp_ff + 16'd8; pc_in = pc1; state_in = ST_RD2; end
               OP_PSH: begin sp_in = sp_ff - 16'd8; pc_in = pc1; end
               OP_EXIT: begin exit_in = rdata_ff; stop_in = 1'b1; end
               default: begin
                  if ((op_ff >= OP_OR) && (op_ff <= OP_MOD)) begin
                     sp_in = sp_ff + 16'd8; pc_in = pc1; state_in = ST_ALU;
                  end else begin
                     fault_in = 1'b1; stop_in = 1'b1;
                  end
               end
            endcase
         end
         ST_RD2: begin
            state_in = ST_RSP;
            if (op_ff == OP_LEV) pc_in = pc_mod(rdata_ff);
            else acc_in = b_sx;
         end
         ST_ALU: begin
            if (alu_rsp.done) begin acc_in = alu_rsp.result; state_in = ST_RSP; end
         end
         ST_RSP: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_index == CSR_START) pc_in = PcW'(csr_wdata[CW-1:0]);
      if (csr_we && csr_index == CSR_STACK) begin sp_in = csr_wdata; fp_in = csr_wdata; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= '0;
         top_ff   <= DefStackTop;
         pc_ff    <= '0;
         sp_ff    <= DefStackTop;
         fp_ff    <= DefStackTop;
         acc_ff   <= '0;
         stop_ff  <= 1'b0;
         fault_ff <= 1'b0;
         exit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         fp_ff    <= fp_in;
         acc_ff   <= acc_in;
         stop_ff  <= stop_in;
         fault_ff <= fault_in;
         exit_ff  <= exit_in;
         if (csr_we && csr_index == CSR_START) start_ff <= csr_wdata[PcW-1:0];
         if (csr_we && csr_index == CSR_STACK) top_ff <= csr_wdata;
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff  <= req_tdata[5:0];
         opd_ff <= req_tdata[69:6];
      end else if (state_ff == ST_EXEC && op_ff == OP_SC) begin
         opd_ff <= rdata_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RSP);
   assign rsp_tdata  = {2'b00, exit_ff, fault_ff, stop_ff, acc_ff, pc_ff};

`ifndef SYNTH
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("overlap");
   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && fault_ff) |-> stop_ff) else $error("fault without halt");
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff) else $error("halt cleared");
   a_cfg_kept: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(start_ff) && $stable(top_ff)) else $error("cfg changed");
`endif

endmodule
`default_nettype wire
